@@ rtl/mbps_pkg.sv @@
// Shared types and constants of the masked byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  localparam int NumSignatures = 2;
  localparam int SigIdxW       = 1;
  localparam int PatW          = 64;
  localparam int CareW         = 8;
  localparam int LenW          = 4;
  localparam int AddrW         = 64;
  localparam int ByteW         = 8;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 64;
  localparam int CntW          = 2;

  localparam logic [PatW-1:0]  PatternZeroReset  = 64'h0000_0000_9090_9090;
  localparam logic [CareW-1:0] CareMaskZeroReset = 8'h0F;
  localparam logic [LenW-1:0]  LengthZeroReset   = 4'd4;
  localparam logic [PatW-1:0]  PatternOneReset   = 64'h0000_0000_0000_00E9;
  localparam logic [CareW-1:0] CareMaskOneReset  = 8'h01;
  localparam logic [LenW-1:0]  LengthOneReset    = 4'd5;
  localparam logic [AddrW-1:0] RegionBaseReset   = 64'h0;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternZero  = 3'd0,
    RegCareMaskZero = 3'd1,
    RegLengthZero   = 3'd2,
    RegPatternOne   = 3'd3,
    RegCareMaskOne  = 3'd4,
    RegLengthOne    = 3'd5,
    RegRegionBase   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [NumSignatures-1:0][PatW-1:0]  pattern;
    logic [NumSignatures-1:0][CareW-1:0] care;
    logic [NumSignatures-1:0][LenW-1:0]  len;
    logic [AddrW-1:0]                    base;
  } mbps_cfg_t;

  typedef struct packed {
    logic [SigIdxW-1:0] sig_idx;
    logic [AddrW-1:0]   addr;
    logic               last;
  } hit_t;

endpackage

`default_nettype wire

@@ rtl/mbps_cfg_regs.sv @@
// Configuration register file of the masked byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]    wr_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0]   wr_data_i,
  output mbps_pkg::mbps_cfg_t             cfg_o
);
  import mbps_pkg::*;

  mbps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        RegPatternZero:  cfg_d.pattern[0] = wr_data_i[PatW-1:0];
        RegCareMaskZero: cfg_d.care[0]    = wr_data_i[CareW-1:0];
        RegLengthZero:   cfg_d.len[0]     = wr_data_i[LenW-1:0];
        RegPatternOne:   cfg_d.pattern[1] = wr_data_i[PatW-1:0];
        RegCareMaskOne:  cfg_d.care[1]    = wr_data_i[CareW-1:0];
        RegLengthOne:    cfg_d.len[1]     = wr_data_i[LenW-1:0];
        RegRegionBase:   cfg_d.base       = wr_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern[0] <= PatternZeroReset;
      cfg_q.care[0]    <= CareMaskZeroReset;
      cfg_q.len[0]     <= LengthZeroReset;
      cfg_q.pattern[1] <= PatternOneReset;
      cfg_q.care[1]    <= CareMaskOneReset;
      cfg_q.len[1]     <= LengthOneReset;
      cfg_q.base       <= RegionBaseReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/mbps_window.sv @@
// Sliding byte window, fill count and region offset of the scanner.
`timescale 1ns / 1ps
`default_nettype none

module mbps_window #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_REGION_BYTES  = 16777216,
  localparam int FillW = $clog2(MAX_PATTERN_BYTES + 1),
  localparam int OffW  = $clog2(MAX_REGION_BYTES) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic [mbps_pkg::ByteW-1:0]  byte_i,
  input  logic                        first_i,
  output logic [mbps_pkg::ByteW-1:0]  win_o [MAX_PATTERN_BYTES],
  output logic [FillW-1:0]            fill_o,
  output logic [OffW-1:0]             off_o,
  output logic                        drop_o
);
  import mbps_pkg::*;

  logic [ByteW-1:0] win_q [MAX_PATTERN_BYTES];
  logic [ByteW-1:0] win_d [MAX_PATTERN_BYTES];
  logic [FillW-1:0] fill_q, fill_d, fill_eff;
  logic [OffW-1:0]  off_q, off_d, off_eff;

  // A region start clears everything before the new byte is shifted in.
  assign fill_eff = first_i ? '0 : fill_q;
  assign off_eff  = first_i ? '0 : off_q;
  assign drop_o   = off_eff >= OffW'(MAX_REGION_BYTES);

  always_comb begin
    win_d[0] = byte_i;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_d[j] = first_i ? '0 : win_q[j-1];
    end
  end

  assign fill_d = (fill_eff < FillW'(MAX_PATTERN_BYTES)) ? fill_eff + 1'b1 : fill_eff;
  assign off_d  = off_eff + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        win_q[j] <= '0;
      end
      fill_q <= '0;
      off_q  <= '0;
    end else if (upd_i && !drop_o) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      off_q  <= off_d;
    end
  end

  assign win_o  = win_d;
  assign fill_o = fill_d;
  assign off_o  = off_d;

endmodule

`default_nettype wire

@@ rtl/mbps_match.sv @@
// Masked compare of one signature against the window and its hit address.
`timescale 1ns / 1ps
`default_nettype none

module mbps_match #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_REGION_BYTES  = 16777216,
  localparam int FillW = $clog2(MAX_PATTERN_BYTES + 1),
  localparam int OffW  = $clog2(MAX_REGION_BYTES) + 1,
  localparam int IdxW  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1
) (
  input  logic [mbps_pkg::ByteW-1:0]  win_i [MAX_PATTERN_BYTES],
  input  logic [FillW-1:0]            fill_i,
  input  logic [OffW-1:0]             off_i,
  input  logic [mbps_pkg::PatW-1:0]   pattern_i,
  input  logic [mbps_pkg::CareW-1:0]  care_i,
  input  logic [mbps_pkg::LenW-1:0]   len_i,
  input  logic [mbps_pkg::AddrW-1:0]  base_i,
  output logic                        hit_o,
  output logic [mbps_pkg::AddrW-1:0]  addr_o
);
  import mbps_pkg::*;

  logic            len_ok, fill_ok, bytes_ok;
  logic [OffW-1:0] start;

  assign len_ok  = (len_i != '0) && (len_i <= LenW'(MAX_PATTERN_BYTES));
  assign fill_ok = LenW'(fill_i) >= len_i;

  // Pattern byte i lines up with window entry len-1-i (entry 0 is newest).
  always_comb begin
    logic [IdxW-1:0] k;
    bytes_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      k = IdxW'(len_i - LenW'(i) - LenW'(1));
      if ((LenW'(i) < len_i) && care_i[i]) begin
        if (win_i[k] != pattern_i[ByteW*i +: ByteW]) begin
          bytes_ok = 1'b0;
        end
      end
    end
  end

  assign hit_o  = len_ok && fill_ok && bytes_ok;
  assign start  = off_i - OffW'(len_i);
  assign addr_o = base_i + AddrW'(start);

endmodule

`default_nettype wire

@@ rtl/mbps_out_buf.sv @@
// Two-entry result register that drains hits one word per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module mbps_out_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [mbps_pkg::CntW-1:0]    load_cnt_i,
  input  mbps_pkg::hit_t               ent0_i,
  input  mbps_pkg::hit_t               ent1_i,
  output logic                         can_load_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mbps_pkg::AddrW-1:0]   m_axis_tdata_o,
  output logic [mbps_pkg::SigIdxW-1:0] m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import mbps_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  hit_t            e0_q, e1_q;
  logic            pop;

  assign pop        = (cnt_q != '0) && m_axis_tready_i;
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = load_cnt_i;
    end else if (pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e0_q <= ent0_i;
      e1_q <= ent1_i;
    end else if (pop) begin
      e0_q <= e1_q;
    end
  end

  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = e0_q.addr;
  assign m_axis_tuser_o  = e0_q.sig_idx;
  assign m_axis_tlast_o  = e0_q.last;

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_scan.sv @@
// Top level of the masked byte pattern scanner.
//
// Usage: bytes of a memory region enter on the slave stream, one byte per word,
// with tuser set on the first byte of each region to clear the window and the
// offset. Each byte is compared against two masked signatures of up to
// MAX_PATTERN_BYTES bytes. Every hit leaves on the master stream as one word:
// tdata is the absolute start address (region base plus start offset), tuser
// is the signature index, and tlast marks the final hit caused by one byte.
// Hits of one byte come out by ascending start address, signature 0 first
// when both start at the same place. Bytes past MAX_REGION_BYTES are dropped.
// A hit becomes valid on the master side once its byte has left the input
// register and the compare and address add have loaded the result register.
// The result register puts out one word per cycle while the receiver is ready,
// so after a byte with two hits the next byte waits in the input register
// while the first of those hits drains from the result register.
// Reset restores the register defaults and clears window, fill count, offset
// and both stream stages. When the receiver stalls, up to two hits wait in the
// result register, one more byte waits in the input register, and then
// s_axis_tready_o drops until the result register drains.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_REGION_BYTES  = 16777216
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream: tdata = data_byte[7:0]; tuser = region_first.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mbps_pkg::ByteW-1:0]    s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  // Master stream: tdata = hit_address[63:0]; tuser = signature_index;
  // tlast = last_of_run.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mbps_pkg::AddrW-1:0]    m_axis_tdata_o,
  output logic [mbps_pkg::SigIdxW-1:0]  m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_data_i
);
  import mbps_pkg::*;

  localparam int FillW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int OffW  = $clog2(MAX_REGION_BYTES) + 1;

  mbps_cfg_t cfg;

  // Input register.
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_first_q;
  logic             adv, can_load;

  // Window state after taking the registered byte.
  logic [ByteW-1:0] win [MAX_PATTERN_BYTES];
  logic [FillW-1:0] fill;
  logic [OffW-1:0]  off;
  logic             drop;

  logic [NumSignatures-1:0] hit_raw, hit_v;
  logic [AddrW-1:0]         addr_v [NumSignatures];

  logic [SigIdxW-1:0] first_k, second_k;
  logic               hf, hs;
  hit_t               ent0, ent1;
  logic [CntW-1:0]    load_cnt;

  assign cfg_ready_o = 1'b1;

  mbps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The registered byte moves on whenever the result register will be free.
  assign adv             = in_vld_q && can_load;
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
    end
  end

  mbps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .MAX_REGION_BYTES  (MAX_REGION_BYTES)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (adv),
    .byte_i  (in_byte_q),
    .first_i (in_first_q),
    .win_o   (win),
    .fill_o  (fill),
    .off_o   (off),
    .drop_o  (drop)
  );

  for (genvar s = 0; s < NumSignatures; s++) begin : g_sig
    mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .MAX_REGION_BYTES  (MAX_REGION_BYTES)
    ) u_match (
      .win_i     (win),
      .fill_i    (fill),
      .off_i     (off),
      .pattern_i (cfg.pattern[s]),
      .care_i    (cfg.care[s]),
      .len_i     (cfg.len[s]),
      .base_i    (cfg.base),
      .hit_o     (hit_raw[s]),
      .addr_o    (addr_v[s])
    );
  end

  // A dropped byte yields no hits.
  assign hit_v = drop ? '0 : hit_raw;

  // The longer signature starts earlier, so it goes first; on a tie
  // signature 0 leads.
  assign first_k  = SigIdxW'(cfg.len[1] > cfg.len[0]);
  assign second_k = ~first_k;
  assign hf       = hit_v[first_k];
  assign hs       = hit_v[second_k];

  always_comb begin
    ent0.sig_idx = hf ? first_k : second_k;
    ent0.addr    = hf ? addr_v[first_k] : addr_v[second_k];
    ent0.last    = !(hf && hs);
    ent1.sig_idx = second_k;
    ent1.addr    = addr_v[second_k];
    ent1.last    = 1'b1;
  end

  assign load_cnt = {hf && hs, hf ^ hs};

  mbps_out_buf u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (adv),
    .load_cnt_i      (load_cnt),
    .ent0_i          (ent0),
    .ent1_i          (ent1),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the masked byte pattern scanner, predicting every hit of every byte.
`timescale 1ns / 1ps

module testbench;
  import mbps_pkg::*;

  // The region cap is set to a small size so that long regions
  // actually run into it within a short simulation.
  localparam int                 RegionCap   = 256;
  localparam int                 WindowDepth = 8;
  localparam int                 StallLimit  = 2000;
  localparam int                 MaxReports  = 10;
  localparam int                 SettleWait  = 4;
  // Index 7 maps to no register; writes to it must leave everything unchanged.
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  // Predicts the hits of each accepted byte and checks the hit words that come out.
  class hit_predictor;
    logic [PatW-1:0]  pattern [NumSignatures];
    logic [CareW-1:0] care    [NumSignatures];
    logic [LenW-1:0]  len     [NumSignatures];
    logic [AddrW-1:0] base;
    logic [ByteW-1:0] window  [WindowDepth];
    int unsigned      fill;
    logic [24:0]      offset;
    hit_t             pending_hits[$];
    int unsigned      mismatches;

    function new();
      pattern[0] = PatternZeroReset;
      care[0]    = CareMaskZeroReset;
      len[0]     = LengthZeroReset;
      pattern[1] = PatternOneReset;
      care[1]    = CareMaskOneReset;
      len[1]     = LengthOneReset;
      base       = RegionBaseReset;
      window     = '{default: '0};
      fill       = 0;
      offset     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegPatternZero:  pattern[0] = data;
        RegCareMaskZero: care[0]    = data[CareW-1:0];
        RegLengthZero:   len[0]     = data[LenW-1:0];
        RegPatternOne:   pattern[1] = data;
        RegCareMaskOne:  care[1]    = data[CareW-1:0];
        RegLengthOne:    len[1]     = data[LenW-1:0];
        RegRegionBase:   base       = data;
        default: ;
      endcase
    endfunction

    // True when signature s ends at the newest byte of the window.
    function bit sig_hits(int s);
      int unsigned n;
      n = len[s];
      if (n == 0 || n > WindowDepth || fill < n) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (care[s][i] && window[n-1-i] != pattern[s][8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [ByteW-1:0] b, logic first);
      bit   hit [NumSignatures];
      int   order [NumSignatures];
      int   n_hits;
      int   emitted;
      int   k;
      hit_t h;
      if (first) begin
        window = '{default: '0};
        fill   = 0;
        offset = '0;
      end
      // Past the cap the byte is dropped without touching the window.
      if (offset >= RegionCap) return;
      for (int i = WindowDepth - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (fill < WindowDepth) fill++;
      offset = offset + 25'd1;
      hit[0] = sig_hits(0);
      hit[1] = sig_hits(1);
      // Hits leave by ascending start address: the longer signature starts earlier.
      if (len[1] > len[0]) begin
        order[0] = 1;
        order[1] = 0;
      end else begin
        order[0] = 0;
        order[1] = 1;
      end
      n_hits  = int'(hit[0]) + int'(hit[1]);
      emitted = 0;
      for (int i = 0; i < NumSignatures; i++) begin
        k = order[i];
        if (hit[k]) begin
          emitted++;
          h.sig_idx = SigIdxW'(k);
          h.addr    = base + AddrW'(offset) - AddrW'(len[k]);
          h.last    = (emitted == n_hits);
          pending_hits = {pending_hits, h};
        end
      end
    endfunction

    function void check_hit(logic [SigIdxW-1:0] sig, logic [AddrW-1:0] addr, logic last);
      hit_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Unexpected hit word: sig %0d addr %h last %0b", sig, addr, last);
        return;
      end
      want = pending_hits.pop_front();
      if (sig !== want.sig_idx || addr !== want.addr || last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Hit mismatch: expected sig %0d addr %h last %0b, got sig %0d addr %h last %0b",
                   want.sig_idx, want.addr, want.last, sig, addr, last);
      end
    endfunction
  endclass

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata   = '0;
  logic                s_axis_tuser   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [AddrW-1:0]    m_axis_tdata;
  logic [SigIdxW-1:0]  m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index      = '0;
  logic [CfgDataW-1:0] cfg_data       = '0;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  stall_cycles  = 0;
  hit_predictor sb            = new();

  always #2 clk = ~clk;

  masked_byte_pattern_scan #(
    .MAX_PATTERN_BYTES(WindowDepth),
    .MAX_REGION_BYTES (RegionCap)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // The receiver stalls at random with the rate of the current phase.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // All handshakes are observed here, at the rising edge, so the predictor sees
  // bytes, hit words and register writes in the order the block does. The
  // watchdog ends the run if nothing moves for too long.
  always @(posedge clk) begin : monitor
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.take_byte(s_axis_tdata, s_axis_tuser);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_hit(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no word moved for %0d cycles", StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Offers one byte, idling first at the sender's rate, and waits until it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Holds the sender back until every predicted hit has arrived, then lets the
  // pipeline settle before the registers may change.
  task automatic wait_idle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_release();
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // New signatures and base; lengths and masks carry random upper bits that the
  // block must ignore, and now and then the unmapped index is written too.
  task automatic randomize_config();
    logic [LenW-1:0]  n;
    logic [CareW-1:0] c;
    logic [AddrW-1:0] a;
    for (int s = 0; s < NumSignatures; s++) begin
      case ($urandom_range(11))
        0:       n = '0;
        1:       n = LenW'($urandom_range(9, 15));
        default: n = LenW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(7))
        0:       c = '0;
        1:       c = '1;
        default: c = CareW'($urandom);
      endcase
      cfg_write(s ? RegPatternOne : RegPatternZero, {$urandom, $urandom});
      cfg_write(s ? RegCareMaskOne : RegCareMaskZero, {$urandom, 24'($urandom), c});
      cfg_write(s ? RegLengthOne : RegLengthZero, {$urandom, 28'($urandom), n});
    end
    case ($urandom_range(5))
      0:       a = '0;
      1:       a = '1 - AddrW'($urandom_range(300));
      default: a = {$urandom, $urandom};
    endcase
    cfg_write(RegRegionBase, a);
    if ($urandom_range(2) == 0) cfg_write(RegUnmapped, {$urandom, $urandom});
    cfg_release();
  endtask

  // Sends regions of random length. Most content is planted signature copies
  // with random don't-care bytes, some of them corrupted in one bit; the rest
  // is random noise, with an occasional stray region restart. Bytes dropped
  // past the cap do not count toward n_items.
  task automatic run_segment(input int unsigned n_items, input bit force_long);
    int unsigned      counted;
    int unsigned      region_len;
    int unsigned      pos;
    int unsigned      sig;
    int unsigned      plen;
    bit               want_long;
    logic [ByteW-1:0] burst[$];
    logic [ByteW-1:0] b;
    logic             first;
    counted    = 0;
    pos        = 0;
    region_len = 0;
    want_long  = force_long;
    while (counted < n_items) begin
      first = 1'b0;
      if (pos >= region_len) begin
        first = 1'b1;
        pos   = 0;
        burst.delete();
        if (want_long || $urandom_range(29) == 0)
          region_len = RegionCap + $urandom_range(2, 20);
        else
          region_len = $urandom_range(1, 40);
        want_long = 1'b0;
      end else if ($urandom_range(59) == 0) begin
        first = 1'b1;
        pos   = 0;
      end
      if (burst.size() == 0 && $urandom_range(99) < 40) begin
        sig  = $urandom_range(NumSignatures - 1);
        plen = sb.len[sig];
        if (plen == 0 || plen > WindowDepth) plen = $urandom_range(1, WindowDepth);
        for (int i = 0; i < plen; i++)
          burst = {burst, sb.care[sig][i] ? sb.pattern[sig][8*i +: 8] : ByteW'($urandom)};
        if ($urandom_range(5) == 0)
          burst[$urandom_range(plen - 1)] ^= ByteW'(1 << $urandom_range(7));
      end
      b = (burst.size() != 0) ? burst.pop_front() : ByteW'($urandom);
      send_byte(b, first);
      if (pos < RegionCap) counted++;
      pos++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset signatures: 0xE9 followed by four 0x90 hits both signatures on the
    // same byte, the longer signature 1 first since it starts earlier.
    send_byte(8'hE9, 1'b1);
    repeat (4) send_byte(8'h90, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Equal lengths and equal start: signature 0 must come first. Care bits
    // above the length and upper length bits are ignored, the base wraps.
    wait_idle();
    cfg_write(RegPatternZero, 64'h0201);
    cfg_write(RegCareMaskZero, 64'hFF);
    cfg_write(RegLengthZero, 64'h12);
    cfg_write(RegPatternOne, 64'hFFFF_FFFF_FFFF_0201);
    cfg_write(RegCareMaskOne, 64'h03);
    cfg_write(RegLengthOne, 64'h2);
    cfg_write(RegRegionBase, '1);
    cfg_write(RegUnmapped, '1);
    cfg_release();
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);

    // Full-length signature with no care bits: silent until the window holds
    // eight bytes, then a hit on every byte. Signature 1 is off by zero length.
    wait_idle();
    cfg_write(RegCareMaskZero, '0);
    cfg_write(RegLengthZero, 64'd8);
    cfg_write(RegLengthOne, 64'd0);
    cfg_write(RegRegionBase, '0);
    cfg_release();
    for (int i = 0; i < 9; i++) send_byte(ByteW'(i * 37), i == 0);

    // A length above the window disables signature 0.
    wait_idle();
    cfg_write(RegLengthZero, 64'd9);
    cfg_write(RegCareMaskOne, '0);
    cfg_write(RegLengthOne, 64'hF3);
    cfg_release();
    for (int i = 0; i < 4; i++) send_byte(ByteW'($urandom), i == 0);

    // Random part in three idling phases, each with a few register settings.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        wait_idle();
        randomize_config();
        run_segment(100, p == 0 && seg == 0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ masked_byte_pattern_scan.f @@
rtl/mbps_pkg.sv
rtl/mbps_cfg_regs.sv
rtl/mbps_window.sv
rtl/mbps_match.sv
rtl/mbps_out_buf.sv
rtl/masked_byte_pattern_scan.sv
bench/testbench.sv
